// ===== rtl/wmfod_pkg.sv =====
// Shared types and constants for the management-frame OUI detector.
package wmfod_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_OUI_COUNT = 3'd0,
        REG_OUI_ZERO  = 3'd1,
        REG_OUI_ONE   = 3'd2,
        REG_OUI_TWO   = 3'd3,
        REG_OUI_THREE = 3'd4
    } t_reg_idx;

    // Record kinds on the output stream
    typedef enum logic [1:0] {
        KIND_DONE  = 2'd0,
        KIND_TX    = 2'd1,
        KIND_RX    = 2'd2,
        KIND_PROBE = 2'd3
    } t_kind;

    localparam int OUI_REGS = 4;
    localparam int COUNT_W  = 3;
    localparam int OUI_W    = 24;
    localparam int MAC_W    = 48;

    // Frame byte positions
    localparam int RX_FIRST      = 4;
    localparam int TX_FIRST      = 10;
    localparam int HDR_BYTES     = 24;
    localparam int TAG_ID_POS    = 24;
    localparam int TAG_LEN_POS   = 25;
    localparam int TAG_END_BYTES = 26;

    localparam logic [3:0] PROBE_SUBTYPE  = 4'h4;
    localparam int         ADDR_GROUP_BIT = 40;  // 0x01 of first address byte
    localparam int         ADDR_LOCAL_BIT = 41;  // 0x02 of first address byte

    // Bit positions in the pending-record mask, in emission order
    localparam int REC_TX    = 0;
    localparam int REC_RX    = 1;
    localparam int REC_PROBE = 2;
    localparam int REC_DONE  = 3;
    localparam int REC_N     = 4;

    typedef struct packed {
        logic [COUNT_W-1:0]             count;
        logic [OUI_REGS-1:0][OUI_W-1:0] oui;
    } t_oui_cfg;

    // Everything needed at frame end, captured with the last byte
    typedef struct packed {
        logic [3:0]        subtype;
        logic              type_mgmt;
        logic [MAC_W-1:0]  rx_addr;
        logic [MAC_W-1:0]  tx_addr;
        logic              tag_zero;
        logic              len_hdr;
        logic              len_tag;
        logic              mgmt;
        logic signed [7:0] dbm;
        logic [3:0]        chan;
        logic [31:0]       total;
    } t_snap;

    typedef struct packed {
        t_kind             kind;
        logic [MAC_W-1:0]  mac;
        logic signed [7:0] dbm;
        logic [3:0]        chan;
        logic [31:0]       total;
        logic              last;
    } t_rec;

endpackage

// ===== rtl/wmfod_capture.sv =====
// Per-byte header capture, byte position tracking and management counter.
module wmfod_capture
    import wmfod_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic              i_end,
    input  logic              i_mgmt,
    input  logic signed [7:0] i_dbm,
    input  logic [3:0]        i_chan,
    output t_snap             o_snap
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_ctrl, n_ctrl;
    logic [MAC_W-1:0] r_rx, n_rx;
    logic [MAC_W-1:0] r_tx, n_tx;
    logic [15:0]      r_tag, n_tag;
    logic [31:0]      r_count, n_count;

    always_comb begin
        n_pos   = r_pos;
        n_ctrl  = r_ctrl;
        n_rx    = r_rx;
        n_tx    = r_tx;
        n_tag   = r_tag;
        n_count = r_count;
        if (r_pos < POS_W'(MAX_FRAME_BYTES)) begin
            n_pos = r_pos + 1'b1;
            if (r_pos == '0) begin
                n_ctrl = i_byte;
            end
            for (int k = 0; k < 6; k++) begin
                if (r_pos == POS_W'(RX_FIRST + k)) begin
                    n_rx[MAC_W-1-8*k -: 8] = i_byte;
                end
                if (r_pos == POS_W'(TX_FIRST + k)) begin
                    n_tx[MAC_W-1-8*k -: 8] = i_byte;
                end
            end
            if (r_pos == POS_W'(TAG_ID_POS)) begin
                n_tag[15:8] = i_byte;
            end
            if (r_pos == POS_W'(TAG_LEN_POS)) begin
                n_tag[7:0] = i_byte;
            end
        end
        if (i_end && i_mgmt) begin
            n_count = r_count + 32'd1;
        end
    end

    // n_pos is the frame length, capped at MAX_FRAME_BYTES, when i_end is set
    always_comb begin
        o_snap.subtype   = n_ctrl[7:4];
        o_snap.type_mgmt = (n_ctrl[3:2] == 2'b00);
        o_snap.rx_addr   = n_rx;
        o_snap.tx_addr   = n_tx;
        o_snap.tag_zero  = (n_tag == 16'd0);
        o_snap.len_hdr   = (n_pos >= POS_W'(HDR_BYTES));
        o_snap.len_tag   = (n_pos >= POS_W'(TAG_END_BYTES));
        o_snap.mgmt      = i_mgmt;
        o_snap.dbm       = i_dbm;
        o_snap.chan      = i_chan;
        o_snap.total     = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_ctrl  <= '0;
            r_rx    <= '0;
            r_tx    <= '0;
            r_tag   <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_pos   <= i_end ? '0 : n_pos;
            r_ctrl  <= n_ctrl;
            r_rx    <= n_rx;
            r_tx    <= n_tx;
            r_tag   <= n_tag;
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/wmfod_emit.sv =====
// Frame-end snapshot, OUI match and record sequencing.
module wmfod_emit
    import wmfod_pkg::*;
#(
    parameter int OUI_SLOTS = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_snap    i_snap,
    input  t_oui_cfg i_cfg,
    input  logic     i_take,
    output logic     o_free,
    output logic     o_rec_valid,
    output t_rec     o_rec
);

    logic             r_valid;
    logic [REC_N-1:0] r_issued;
    t_snap            r_snap;

    logic [REC_N-1:0] rec_mask;
    logic [REC_N-1:0] pend;
    logic [REC_N-1:0] sel;
    logic             tx_hit;
    logic             rx_hit;
    logic             hdr_ok;

    function automatic logic oui_hit(input logic [MAC_W-1:0] addr, input t_oui_cfg cfg);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < OUI_REGS; i++) begin
            if (i < OUI_SLOTS && COUNT_W'(i) < cfg.count
                && cfg.oui[i] == addr[MAC_W-1 -: OUI_W]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    always_comb begin
        hdr_ok = r_snap.mgmt && r_snap.len_hdr && r_snap.type_mgmt;
        tx_hit = oui_hit(r_snap.tx_addr, i_cfg);
        rx_hit = !r_snap.rx_addr[ADDR_GROUP_BIT] && !r_snap.rx_addr[ADDR_LOCAL_BIT]
                 && oui_hit(r_snap.rx_addr, i_cfg);
        rec_mask            = '0;
        rec_mask[REC_TX]    = hdr_ok && tx_hit;
        rec_mask[REC_RX]    = hdr_ok && rx_hit;
        rec_mask[REC_PROBE] = hdr_ok && tx_hit && r_snap.len_tag && r_snap.tag_zero
                              && (r_snap.subtype == PROBE_SUBTYPE);
        rec_mask[REC_DONE]  = 1'b1;
        pend = rec_mask & ~r_issued;
    end

    always_comb begin
        sel            = '0;
        o_rec.dbm      = r_snap.dbm;
        o_rec.chan     = r_snap.chan;
        o_rec.total    = r_snap.total;
        o_rec.kind     = KIND_DONE;
        o_rec.mac      = '0;
        o_rec.last     = 1'b1;
        sel[REC_DONE]  = 1'b1;
        if (pend[REC_TX]) begin
            sel        = '0;
            sel[REC_TX] = 1'b1;
            o_rec.kind = KIND_TX;
            o_rec.mac  = r_snap.tx_addr;
            o_rec.last = 1'b0;
        end else if (pend[REC_RX]) begin
            sel        = '0;
            sel[REC_RX] = 1'b1;
            o_rec.kind = KIND_RX;
            o_rec.mac  = r_snap.rx_addr;
            o_rec.last = 1'b0;
        end else if (pend[REC_PROBE]) begin
            sel        = '0;
            sel[REC_PROBE] = 1'b1;
            o_rec.kind = KIND_PROBE;
            o_rec.mac  = r_snap.tx_addr;
            o_rec.last = 1'b0;
        end
    end

    assign o_rec_valid = r_valid;
    assign o_free      = !r_valid || (i_take && o_rec.last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_issued <= '0;
        end else if (i_load) begin
            r_valid  <= 1'b1;
            r_issued <= '0;
        end else if (i_take) begin
            if (o_rec.last) begin
                r_valid <= 1'b0;
            end else begin
                r_issued <= r_issued | sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_snap <= i_snap;
        end
    end

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("snapshot loaded while records still pending");

    a_last_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rec_valid && o_rec.last) |-> (o_rec.kind == KIND_DONE))
        else $error("run closed by a detection record");

    a_hold_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_take && !o_rec.last) |=> r_valid)
        else $error("run dropped before frame-done record");

    a_done_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !r_issued[REC_DONE])
        else $error("frame-done record marked issued while run open");
`endif

endmodule

// ===== rtl/wifi_mgmt_frame_oui_detector.sv =====
// Top level of the 802.11 management-frame vendor OUI detector.
//
//  channel   dir  handshake                  payload
//  s stream  in   i_s_tvalid / o_s_tready    tdata {chan,dbm,byte}, tlast end, tuser mgmt
//  m stream  out  o_m_tvalid / i_m_tready    tdata {total,chan,dbm,mac}, tlast, tuser kind
//  cfg       in   i_cfg_we                   i_cfg_addr index, i_cfg_wdata value
//
// One input word per cycle inside a frame while o_s_tready is high; a non-final word gives no output.
// The final word loads the frame snapshot; it yields 1 to 4 record words, one
// per cycle through the output register while i_m_tready allows, so o_s_tready
// stays low until the last record leaves the snapshot (single snapshot slot).
// Synchronous active-low reset clears position, counter, config and valids.
// Output stalls hold the output register, then the snapshot, then the input.
module wifi_mgmt_frame_oui_detector
    import wmfod_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 4096,
    parameter int OUI_SLOTS       = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [7:0] frame_byte, [15:8] signal_dbm, [19:16] radio_channel
    input  logic        i_s_tlast,   // frame_end
    input  logic        i_s_tuser,   // [0] is_mgmt_packet
    // master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [95:0] o_m_tdata,   // [47:0] station_mac, [55:48] hit_dbm,
                                     // [59:56] hit_channel, [91:60] mgmt_total
    output logic        o_m_tlast,   // run_last
    output logic [1:0]  o_m_tuser,   // [1:0] record_kind
    // config write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_wdata
);

    t_oui_cfg r_cfg;
    t_snap    snap;
    t_rec     rec;
    t_rec     r_out;
    logic     r_out_valid;
    logic     rec_valid;
    logic     rec_take;
    logic     snap_free;
    logic     s_accept;

    // Config registers; the user must write them only while the block is idle (not enforced here)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_OUI_COUNT: r_cfg.count  <= i_cfg_wdata[COUNT_W-1:0];
                REG_OUI_ZERO:  r_cfg.oui[0] <= i_cfg_wdata;
                REG_OUI_ONE:   r_cfg.oui[1] <= i_cfg_wdata;
                REG_OUI_TWO:   r_cfg.oui[2] <= i_cfg_wdata;
                REG_OUI_THREE: r_cfg.oui[3] <= i_cfg_wdata;
                default:       ;  // unmapped index, dropped
            endcase
        end
    end

    assign o_s_tready = snap_free;
    assign s_accept   = i_s_tvalid && snap_free;

    wmfod_capture #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_capture (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_accept),
        .i_byte   (i_s_tdata[7:0]),
        .i_end    (i_s_tlast),
        .i_mgmt   (i_s_tuser),
        .i_dbm    (i_s_tdata[15:8]),
        .i_chan   (i_s_tdata[19:16]),
        .o_snap   (snap)
    );

    wmfod_emit #(
        .OUI_SLOTS(OUI_SLOTS)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (s_accept && i_s_tlast),
        .i_snap      (snap),
        .i_cfg       (r_cfg),
        .i_take      (rec_take),
        .o_free      (snap_free),
        .o_rec_valid (rec_valid),
        .o_rec       (rec)
    );

    // Output register: refills in the cycle the current word leaves
    assign rec_take = rec_valid && (!r_out_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rec_take) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rec_take) begin
            r_out <= rec;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out.total, r_out.chan, r_out.dbm, r_out.mac};
    assign o_m_tlast  = r_out.last;
    assign o_m_tuser  = r_out.kind;

endmodule

// ===== tb/sv/tb_wifi_mgmt_frame_oui_detector.sv =====
// Self-checking testbench for the management-frame vendor OUI detector.
`timescale 1ns / 1ps

import wmfod_pkg::*;

localparam int FRAME_CAP  = 32;     // byte position saturates here
localparam int OUI_SLOTS_TB = 4;

typedef logic [7:0] t_frame_q [$];

// Tracks the detector state, predicts the records of every frame and checks
// each record that leaves the block against the oldest prediction.
class oui_hit_tracker;
    logic [2:0]  oui_count;
    logic [23:0] oui_tab [OUI_REGS];
    logic [12:0] pos;
    logic [7:0]  fc;
    logic [47:0] ra;
    logic [47:0] ta;
    logic [15:0] tag;
    logic [31:0] mgmt_cnt;
    t_rec        due_records [$];
    int          mismatches;

    function new();
        oui_count  = '0;
        foreach (oui_tab[i]) oui_tab[i] = '0;
        pos        = '0;
        fc         = '0;
        ra         = '0;
        ta         = '0;
        tag        = '0;
        mgmt_cnt   = '0;
        mismatches = 0;
    endfunction

    function void set_reg(t_reg_idx idx, logic [23:0] val);
        case (idx)
            REG_OUI_COUNT: oui_count  = val[COUNT_W-1:0];
            REG_OUI_ZERO:  oui_tab[0] = val;
            REG_OUI_ONE:   oui_tab[1] = val;
            REG_OUI_TWO:   oui_tab[2] = val;
            REG_OUI_THREE: oui_tab[3] = val;
            default: ;
        endcase
    endfunction

    // Count clamps to the slots that exist
    function bit vendor_known(logic [47:0] addr);
        int n;
        n = oui_count;
        if (n > OUI_SLOTS_TB) n = OUI_SLOTS_TB;
        if (n > OUI_REGS) n = OUI_REGS;
        for (int i = 0; i < n; i++)
            if (oui_tab[i] == addr[47:24]) return 1'b1;
        return 1'b0;
    endfunction

    function void push_rec(t_kind k, logic [47:0] mac, logic [7:0] dbm,
                           logic [3:0] ch, logic fin);
        t_rec r;
        r.kind  = k;
        r.mac   = mac;
        r.dbm   = dbm;
        r.chan  = ch;
        r.total = mgmt_cnt;
        r.last  = fin;
        due_records.push_back(r);
    endfunction

    // One accepted input word
    function void take_byte(logic [7:0] b, logic fin, logic mgmt, logic [7:0] dbm,
                            logic [3:0] ch);
        logic [12:0] len;
        bit          tx_hit;
        if (pos < FRAME_CAP) begin
            if (pos == 0)
                fc = b;
            else if (pos >= RX_FIRST && pos < RX_FIRST + 6)
                ra[8*(RX_FIRST + 5 - pos) +: 8] = b;
            else if (pos >= TX_FIRST && pos < TX_FIRST + 6)
                ta[8*(TX_FIRST + 5 - pos) +: 8] = b;
            else if (pos == TAG_ID_POS)
                tag[15:8] = b;
            else if (pos == TAG_LEN_POS)
                tag[7:0] = b;
            pos = pos + 1'b1;
        end
        if (!fin) return;
        len = pos;
        pos = '0;
        if (mgmt) begin
            mgmt_cnt = mgmt_cnt + 1;
            if (len >= HDR_BYTES && fc[3:2] == 2'b00) begin
                tx_hit = vendor_known(ta);
                if (tx_hit)
                    push_rec(KIND_TX, ta, dbm, ch, 1'b0);
                if (!ra[ADDR_GROUP_BIT] && !ra[ADDR_LOCAL_BIT] && vendor_known(ra))
                    push_rec(KIND_RX, ra, dbm, ch, 1'b0);
                if (fc[7:4] == PROBE_SUBTYPE && len >= TAG_END_BYTES && tx_hit
                    && tag == 16'h0000)
                    push_rec(KIND_PROBE, ta, dbm, ch, 1'b0);
            end
        end
        push_rec(KIND_DONE, 48'h0, dbm, ch, 1'b1);
    endfunction

    // One accepted output word
    function void match_record(t_kind k, logic [47:0] mac, logic [7:0] dbm,
                               logic [3:0] ch, logic [31:0] total, logic fin);
        t_rec want;
        bit   bad;
        if (due_records.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected record: kind %0d mac %h dbm %0d ch %0d total %0d last %0b",
                         k, mac, $signed(dbm), ch, total, fin);
            return;
        end
        want = due_records.pop_front();
        bad = (want.kind !== k) || (want.mac !== mac) || (want.dbm !== dbm)
              || (want.chan !== ch) || (want.total !== total) || (want.last !== fin);
        if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("record mismatch: want kind %0d mac %h dbm %0d ch %0d total %0d last %0b",
                         want.kind, want.mac, want.dbm, want.chan, want.total, want.last);
                $display("                  got kind %0d mac %h dbm %0d ch %0d total %0d last %0b",
                         k, mac, $signed(dbm), ch, total, fin);
            end
        end
    endfunction
endclass

module tb_wifi_mgmt_frame_oui_detector;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;    // long receiver stall, fills the block

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        s_tuser = 1'b0;
    logic        m_tready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [23:0] cfg_wdata = '0;

    logic        s_tready;
    logic        m_tvalid;
    logic [95:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    oui_hit_tracker tracker = new();

    int cycle_count = 0;
    int bytes_sent = 0;
    int records_seen = 0;
    int hold_req = 0;      // main sets it, receiver consumes it
    bit rx_calm = 1'b0;    // receiver runs without stalls while set

    wifi_mgmt_frame_oui_detector #(
        .MAX_FRAME_BYTES(FRAME_CAP),
        .OUI_SLOTS      (OUI_SLOTS_TB)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Runaway guard
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Output monitor: values sampled here are the ones seen by this edge.
    // tdata: [47:0] mac, [55:48] dbm, [59:56] channel, [91:60] mgmt total
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            tracker.match_record(t_kind'(m_tuser), m_tdata[47:0], m_tdata[55:48],
                                 m_tdata[59:56], m_tdata[91:60], m_tlast);
            records_seen++;
        end
    end

    // Receiver: random stall per word, calm stretches, one long hold-off
    initial begin
        int stall;
        int words;
        words = 0;
        repeat (6) @(posedge clk);
        forever begin
            if (hold_req > 0) begin
                stall = hold_req;
                hold_req = 0;
            end else begin
                stall = rx_calm ? 0 : $urandom_range(0, 8);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            words++;
            if (words % 40 == 0) rx_calm = ($urandom_range(0, 2) == 0);
        end
    end

    // Builds frame bytes: header fields at their fixed positions, rest random
    function automatic t_frame_q make_frame(int len, logic [7:0] ctl, logic [47:0] rxa,
                                            logic [47:0] txa, logic [7:0] tag_id,
                                            logic [7:0] tag_len);
        t_frame_q q;
        for (int i = 0; i < len; i++) begin
            if (i == 0)
                q.push_back(ctl);
            else if (i >= RX_FIRST && i < RX_FIRST + 6)
                q.push_back(rxa[8*(RX_FIRST + 5 - i) +: 8]);
            else if (i >= TX_FIRST && i < TX_FIRST + 6)
                q.push_back(txa[8*(TX_FIRST + 5 - i) +: 8]);
            else if (i == TAG_ID_POS)
                q.push_back(tag_id);
            else if (i == TAG_LEN_POS)
                q.push_back(tag_len);
            else
                q.push_back(8'($urandom_range(0, 255)));
        end
        return q;
    endfunction

    // Streams one frame. Side fields are random on inner words; only the
    // last word's mgmt flag, dbm and channel matter.
    task automatic send_frame(input t_frame_q frame, input logic mgmt,
                              input logic [7:0] dbm, input logic [3:0] ch);
        int         gap;
        bit         calm;
        logic       fin;
        logic       w_mgmt;
        logic [7:0] w_dbm;
        logic [3:0] w_ch;
        calm = ($urandom_range(0, 3) == 0);
        foreach (frame[i]) begin
            gap = calm ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            fin    = (i == frame.size() - 1);
            w_mgmt = fin ? mgmt : 1'($urandom_range(0, 1));
            w_dbm  = fin ? dbm : 8'($urandom_range(0, 255));
            w_ch   = fin ? ch : 4'($urandom_range(0, 15));
            s_tvalid <= 1'b1;
            // tdata: [7:0] frame byte, [15:8] dbm, [19:16] channel
            s_tdata  <= {4'h0, w_ch, w_dbm, frame[i]};
            s_tlast  <= fin;
            s_tuser  <= w_mgmt;
            @(posedge clk);
            while (!s_tready) @(posedge clk);
            tracker.take_byte(frame[i], fin, w_mgmt, w_dbm, w_ch);
            bytes_sent++;
        end
    endtask

    task automatic frame_with(input int len, input logic [7:0] ctl, input logic [47:0] rxa,
                              input logic [47:0] txa, input logic [7:0] tag_id,
                              input logic [7:0] tag_len, input logic mgmt,
                              input logic [7:0] dbm, input logic [3:0] ch);
        send_frame(make_frame(len, ctl, rxa, txa, tag_id, tag_len), mgmt, dbm, ch);
    endtask

    // Register writes back to back, in index order
    task automatic write_regs(input logic [2:0] count, input logic [23:0] o0,
                              input logic [23:0] o1, input logic [23:0] o2,
                              input logic [23:0] o3);
        logic [23:0] vals [5];
        t_reg_idx    idx;
        vals = '{{21'h0, count}, o0, o1, o2, o3};
        for (int i = 0; i < 5; i++) begin
            idx = t_reg_idx'(i);
            cfg_we    <= 1'b1;
            cfg_addr  <= idx;
            cfg_wdata <= vals[i];
            @(posedge clk);
            tracker.set_reg(idx, vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // Drain everything and idle before touching registers
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.due_records.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [23:0] pick_oui();
        case ($urandom_range(0, 3))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return {8'($urandom_range(0, 255)) & 8'hFC, 16'($urandom_range(0, 65535))};
        endcase
    endfunction

    task automatic random_config();
        write_regs(3'($urandom_range(0, 7)), pick_oui(), pick_oui(), pick_oui(), pick_oui());
    endtask

    // Mostly well-formed management frames carrying configured OUIs; the
    // rest is noise: any length, any control byte, any addresses.
    task automatic random_frame();
        logic [7:0]  ctl;
        logic [47:0] rxa;
        logic [47:0] txa;
        logic [7:0]  tid;
        logic [7:0]  tln;
        logic        mgmt;
        int          len;
        if ($urandom_range(0, 9) < 7) begin
            ctl = {($urandom_range(0, 1) ? PROBE_SUBTYPE : 4'($urandom_range(0, 15))),
                   2'b00, 2'($urandom_range(0, 3))};
            txa = {($urandom_range(0, 3) != 0) ? tracker.oui_tab[$urandom_range(0, 3)]
                                                : 24'($urandom), 24'($urandom)};
            rxa = {($urandom_range(0, 3) != 0) ? tracker.oui_tab[$urandom_range(0, 3)]
                                                : 24'($urandom), 24'($urandom)};
            if ($urandom_range(0, 1)) rxa[ADDR_LOCAL_BIT:ADDR_GROUP_BIT] = 2'b00;
            case ($urandom_range(0, 5))
                0:       len = HDR_BYTES;
                1:       len = TAG_LEN_POS;
                2:       len = TAG_END_BYTES;
                default: len = $urandom_range(27, 48);
            endcase
            tid  = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255));
            tln  = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255));
            mgmt = ($urandom_range(0, 9) != 0);
        end else begin
            ctl  = 8'($urandom_range(0, 255));
            rxa  = {16'($urandom), 32'($urandom)};
            txa  = {16'($urandom), 32'($urandom)};
            len  = $urandom_range(1, 40);
            tid  = 8'($urandom_range(0, 255));
            tln  = 8'($urandom_range(0, 255));
            mgmt = 1'($urandom_range(0, 1));
        end
        frame_with(len, ctl, rxa, txa, tid, tln, mgmt, 8'($urandom_range(0, 255)),
                   4'($urandom_range(0, 15)));
    endtask

    // Fixed addresses for the directed frames
    localparam logic [47:0] TX_ZERO  = {24'h000000, 24'h123456};
    localparam logic [47:0] TX_ONES  = {24'hFFFFFF, 24'hABCDEF};
    localparam logic [47:0] TX_LOCAL = {24'h02AB12, 24'h445566};
    localparam logic [47:0] RX_UNI   = {24'h00A0C6, 24'h010203};
    localparam logic [47:0] RX_GROUP = {24'hFFFFFF, 24'h0A0B0C};
    localparam logic [47:0] RX_LOCAL = {24'h02AB12, 24'h778899};
    localparam logic [47:0] NO_MATCH = {24'h5C1F00, 24'h654321};

    initial begin
        int rand_start;
        int phase;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers at reset: nothing configured, no hits
        frame_with(26, 8'h40, RX_UNI, TX_ZERO, 8'h00, 8'h00, 1'b1, 8'h11, 4'h3);
        wait_idle();

        write_regs(3'd4, 24'h000000, 24'hFFFFFF, 24'h00A0C6, 24'h02AB12);
        // one-byte frame, weakest signal, lowest channel
        frame_with(1, 8'h00, RX_UNI, TX_ZERO, 8'h00, 8'h00, 1'b1, 8'h80, 4'h0);
        // one byte short of a full header
        frame_with(23, 8'h00, RX_UNI, TX_ZERO, 8'h00, 8'h00, 1'b1, 8'h00, 4'h7);
        // bare header: tx and rx hits, strongest signal, top channel
        frame_with(24, 8'h00, RX_UNI, TX_ZERO, 8'h00, 8'h00, 1'b1, 8'h7F, 4'hF);
        // wildcard probe: all four records
        frame_with(26, 8'h40, RX_UNI, TX_ONES, 8'h00, 8'h00, 1'b1, 8'hC4, 4'h6);
        // probe too short for tags, group receiver skipped
        frame_with(25, 8'h40, RX_GROUP, TX_ONES, 8'h00, 8'h00, 1'b1, 8'hB0, 4'h1);
        // local receiver skipped, tag length nonzero
        frame_with(26, 8'h40, RX_LOCAL, TX_ONES, 8'h00, 8'h05, 1'b1, 8'hD8, 4'h9);
        // tag id nonzero, longer frame
        frame_with(30, 8'h40, NO_MATCH, TX_ONES, 8'h05, 8'h00, 1'b1, 8'h20, 4'hB);
        // rx hit only: no probe record without a tx hit
        frame_with(26, 8'h40, RX_UNI, NO_MATCH, 8'h00, 8'h00, 1'b1, 8'hE0, 4'h2);
        // data and control frame types give only the closing record
        frame_with(26, 8'h48, RX_UNI, TX_ZERO, 8'h00, 8'h00, 1'b1, 8'h9C, 4'h4);
        frame_with(26, 8'h44, RX_UNI, TX_ZERO, 8'h00, 8'h00, 1'b1, 8'h9D, 4'h5);
        // not classed management: counter holds
        frame_with(26, 8'h40, RX_UNI, TX_ONES, 8'h00, 8'h00, 1'b0, 8'hA5, 4'hC);
        // over-long frame: position saturates, tail ignored
        frame_with(FRAME_CAP + 4, 8'h00, RX_UNI, TX_ZERO, 8'h00, 8'h00, 1'b1, 8'h3C, 4'hD);
        // top subtype, locally administered transmitter still matches
        frame_with(24, 8'hF3, RX_GROUP, TX_LOCAL, 8'h00, 8'h00, 1'b1, 8'h5A, 4'hE);
        wait_idle();

        // count above the slot number clamps to four
        write_regs(3'd7, 24'h000000, 24'hFFFFFF, 24'h00A0C6, 24'h02AB12);
        frame_with(26, 8'h40, RX_LOCAL, TX_LOCAL, 8'h00, 8'h00, 1'b1, 8'h01, 4'h8);
        wait_idle();

        // only the first slot counts
        write_regs(3'd1, 24'hFFFFFF, 24'h000000, 24'h00A0C6, 24'h000000);
        frame_with(26, 8'h40, RX_UNI, TX_ZERO, 8'h00, 8'h00, 1'b1, 8'h02, 4'hA);
        frame_with(26, 8'h40, RX_UNI, TX_ONES, 8'h00, 8'h00, 1'b1, 8'h03, 4'h6);
        wait_idle();

        write_regs(3'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        frame_with(26, 8'h40, RX_UNI, TX_ONES, 8'h00, 8'h00, 1'b1, 8'h04, 4'h9);
        wait_idle();

        // Random phases, each under a fresh register setting; the first one
        // runs under the long receiver hold-off
        rand_start = bytes_sent;
        phase = 0;
        while (bytes_sent - rand_start < 100) begin
            random_config();
            if (phase == 0) hold_req = HOLD_CYCLES;
            repeat (6) random_frame();
            wait_idle();
            phase++;
        end

        repeat (20) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.due_records.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/wmfod_pkg.sv
rtl/wmfod_capture.sv
rtl/wmfod_emit.sv
rtl/wifi_mgmt_frame_oui_detector.sv
tb/sv/tb_wifi_mgmt_frame_oui_detector.sv
